/* rtl/core/assert_macros.svh */
// Assertion macros shared by the clusterer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define KML_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property checked on every edge, reset included.
`define KML_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/kml_pkg.sv */
// Shared constants, codes and types of the k-means clusterer.
// No dependencies; used by every module in rtl/core.
package kml_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 8;
  localparam int DIMS         = 4;

  localparam int COORD_W = 16;
  localparam int FRAC_W  = 16;
  localparam int PT_AW   = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int CL_W    = $clog2(MAX_CLUSTERS);
  localparam int K_W     = $clog2(MAX_CLUSTERS + 1);
  localparam int DIM_IW  = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int DIM_CW  = $clog2(DIMS + 1);
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;          // |diff| <= 2^16-1, square < 2^32
  localparam int DIST_W  = SQ_W + $clog2(DIMS);
  localparam int TOT_W   = DIST_W + PT_AW;
  localparam int SUM_W   = COORD_W + PT_AW;
  localparam int FIFO_DEPTH = 4;

  localparam logic [2:0] KIND_CLEAR = 3'd0;
  localparam logic [2:0] KIND_LOAD  = 3'd1;
  localparam logic [2:0] KIND_FRAC  = 3'd2;
  localparam logic [2:0] KIND_RUN   = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_PTS   = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_BAD_IDX  = 2'd3;

  localparam logic [1:0] CFG_NUM_CLUSTERS = 2'd0;
  localparam logic [1:0] CFG_MAX_ITER     = 2'd1;
  localparam logic [1:0] CFG_DIMS         = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef coord_t [DIMS-1:0] point_t;
  typedef logic [DIMS-1:0][SUM_W-1:0] sum_row_t;

  typedef struct packed {
    logic              start;
    logic [DIM_CW-1:0] dims;
  } dist_req_t;

  typedef struct packed {
    logic [2:0]       label;
    logic [7:0]       iterations;
    logic [CNT_W-1:0] points_loaded;
    logic [1:0]       status;
  } result_t;

endpackage

/* rtl/core/kml_dist.sv */
// Squared Euclidean distance unit, one coordinate term per cycle.
// Depends on kml_pkg.
module kml_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  kml_pkg::dist_req_t            req,
  input  kml_pkg::point_t               pt,
  input  kml_pkg::point_t               ctr,
  output logic                          done,
  output logic [kml_pkg::DIST_W-1:0]    sqdist
);

  logic                          issuing;
  logic [kml_pkg::DIM_IW-1:0]    d;
  logic [kml_pkg::DIM_CW-1:0]    dims_r;
  kml_pkg::point_t               pt_r;
  kml_pkg::point_t               ctr_r;
  logic                          s1_v, s1_last, s2_v, s2_last;
  logic signed [kml_pkg::DIFF_W-1:0]   diff;
  logic signed [2*kml_pkg::DIFF_W-1:0] prod;
  logic [kml_pkg::SQ_W-1:0]      sq;
  logic                          last;

  assign last = (kml_pkg::DIM_CW'(d) + 1'b1) == dims_r;
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      done    <= 1'b0;
    end else begin
      done    <= s2_v & s2_last;
      s2_v    <= s1_v;
      s2_last <= s1_last;
      if (req.start) begin
        issuing <= 1'b1;
        d       <= '0;
        dims_r  <= req.dims;
        pt_r    <= pt;
        ctr_r   <= ctr;
        s1_v    <= 1'b0;
      end else if (issuing) begin
        s1_v    <= 1'b1;
        s1_last <= last;
        d       <= d + 1'b1;
        if (last) issuing <= 1'b0;
      end else begin
        s1_v <= 1'b0;
      end
    end
  end

  // datapath: difference, square, accumulate
  always_ff @(posedge clk) begin
    diff <= $signed({pt_r[d][kml_pkg::COORD_W-1], pt_r[d]})
          - $signed({ctr_r[d][kml_pkg::COORD_W-1], ctr_r[d]});
    sq   <= prod[kml_pkg::SQ_W-1:0];
    if (req.start) sqdist <= '0;
    else if (s2_v) sqdist <= sqdist + kml_pkg::DIST_W'(sq);
  end

endmodule

/* rtl/core/kml_div.sv */
// Restoring divider for cluster means: signed sum over unsigned count,
// quotient truncated toward zero. Depends on kml_pkg.
module kml_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [kml_pkg::SUM_W-1:0]  dividend,
  input  logic [kml_pkg::CNT_W-1:0]         divisor,
  output logic                              done,
  output kml_pkg::coord_t                   quotient
);

  localparam int STEP_W = $clog2(kml_pkg::SUM_W);

  logic                        busy;
  logic [STEP_W-1:0]           step;
  logic [kml_pkg::SUM_W-1:0]   q;
  logic [kml_pkg::CNT_W-1:0]   r;
  logic [kml_pkg::CNT_W-1:0]   den;
  logic                        neg;
  logic [kml_pkg::CNT_W:0]     t, t_sub;
  logic                        ge;

  assign t        = {r, q[kml_pkg::SUM_W-1]};
  assign t_sub    = t - {1'b0, den};
  assign ge       = t >= {1'b0, den};
  assign quotient = kml_pkg::COORD_W'(neg ? (kml_pkg::SUM_W'(0) - q) : q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        neg  <= dividend[kml_pkg::SUM_W-1];
        q    <= dividend[kml_pkg::SUM_W-1] ? (kml_pkg::SUM_W'(0) - dividend) : dividend;
        r    <= '0;
        den  <= divisor;
      end else if (busy) begin
        r    <= ge ? t_sub[kml_pkg::CNT_W-1:0] : t[kml_pkg::CNT_W-1:0];
        q    <= {q[kml_pkg::SUM_W-2:0], ge};
        step <= step + 1'b1;
        if (step == STEP_W'(kml_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/kmeans_lloyd_plusplus_clusterer_unit.sv */
// K-means clusterer, top level: point/label/distance memories, run sequencer,
// result queue. Depends on kml_pkg, kml_dist, kml_div and assert_macros.svh.
//
// Each transaction on the input channel gives exactly one result transaction.
// Clear, load point, load fraction, label read and unused kinds stream back
// to back while the result queue has room; a 4-entry result queue lets input
// continue while results wait. A run transaction holds off input until
// clustering is done: a label clearing pass over all 1024 point slots, then
// k-means++ seeding, then Lloyd rounds. Every point visit is a registered
// read of the point memory and a pass of the distance unit, which handles one
// coordinate per cycle for each center. Each added seeding center costs a
// distance pass over all points plus a cumulative pick; each Lloyd round
// costs an assignment pass over all points against every center, plus a
// serial divider run per nonempty cluster and coordinate for the mean update.
// Configuration writes are taken every cycle; change them only while idle.
// Label reads before the first run after reset return zero.
`include "assert_macros.svh"

module kmeans_lloyd_plusplus_clusterer_unit (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           kind,
  input  logic signed [15:0]   coord_0,
  input  logic signed [15:0]   coord_1,
  input  logic signed [15:0]   coord_2,
  input  logic signed [15:0]   coord_3,
  input  logic [15:0]          fraction,
  input  logic [9:0]           point_index,
  // output channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           label,
  output logic [7:0]           iterations,
  output logic [10:0]          points_loaded,
  output logic [1:0]           status
);

  localparam int PT_AW  = kml_pkg::PT_AW;
  localparam int CNT_W  = kml_pkg::CNT_W;
  localparam int CL_W   = kml_pkg::CL_W;
  localparam int K_W    = kml_pkg::K_W;
  localparam int DIST_W = kml_pkg::DIST_W;
  localparam int TOT_W  = kml_pkg::TOT_W;
  localparam int DIMS   = kml_pkg::DIMS;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CLR      = 5'd1;
  localparam logic [4:0] S_SEED0_RD = 5'd2;
  localparam logic [4:0] S_SEED0_WR = 5'd3;
  localparam logic [4:0] S_NDP_RD   = 5'd4;
  localparam logic [4:0] S_NDP_LAT  = 5'd5;
  localparam logic [4:0] S_NDP_ST   = 5'd6;
  localparam logic [4:0] S_NDP_DIST = 5'd7;
  localparam logic [4:0] S_THR1     = 5'd8;
  localparam logic [4:0] S_THR2     = 5'd9;
  localparam logic [4:0] S_CUM_RD   = 5'd10;
  localparam logic [4:0] S_CUM_CHK  = 5'd11;
  localparam logic [4:0] S_SETC_RD  = 5'd12;
  localparam logic [4:0] S_SETC_WR  = 5'd13;
  localparam logic [4:0] S_RND      = 5'd14;
  localparam logic [4:0] S_AS_RD    = 5'd15;
  localparam logic [4:0] S_AS_LAT   = 5'd16;
  localparam logic [4:0] S_AS_ST    = 5'd17;
  localparam logic [4:0] S_AS_DIST  = 5'd18;
  localparam logic [4:0] S_AS_WB    = 5'd19;
  localparam logic [4:0] S_AS_END   = 5'd20;
  localparam logic [4:0] S_UPD      = 5'd21;
  localparam logic [4:0] S_UPD_WAIT = 5'd22;
  localparam logic [4:0] S_DONE     = 5'd23;

  // configuration registers
  logic [3:0] num_clusters;
  logic [7:0] max_iterations;
  logic [2:0] dims_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters   <= 4'd2;
      max_iterations <= 8'd100;
      dims_in_use    <= 3'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        kml_pkg::CFG_NUM_CLUSTERS: num_clusters   <= cfg_data[3:0];
        kml_pkg::CFG_MAX_ITER:     max_iterations <= cfg_data;
        kml_pkg::CFG_DIMS:         dims_in_use    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // block state
  logic [4:0]            state;
  logic [CNT_W-1:0]      pt_total;
  logic [CL_W-1:0]       frac_total;
  logic [kml_pkg::FRAC_W-1:0] frac_tab [kml_pkg::MAX_CLUSTERS];
  logic [7:0]            last_it;
  logic                  ran;
  logic [PT_AW-1:0]      idx;
  logic [K_W-1:0]        k_r;
  logic [kml_pkg::DIM_CW-1:0] dims_r;
  logic [1:0]            run_status;
  logic [CL_W-1:0]       c, cc, uc, best;
  logic [kml_pkg::DIM_IW-1:0] ud;
  logic [7:0]            it;
  logic                  changed;
  logic [TOT_W-1:0]      total, thr, cum;
  logic [31:0]           p_lo;
  logic [TOT_W-1:0]      p_hi;
  logic [DIST_W-1:0]     cur_nd, bd;
  logic [2:0]            cur_lab;
  kml_pkg::point_t       cur_pt;
  kml_pkg::point_t       centers [kml_pkg::MAX_CLUSTERS];
  kml_pkg::sum_row_t     sums    [kml_pkg::MAX_CLUSTERS];
  logic [CNT_W-1:0]      counts  [kml_pkg::MAX_CLUSTERS];

  // memories
  kml_pkg::point_t       pstore [kml_pkg::MAX_POINTS];
  logic [DIST_W-1:0]     ndist  [kml_pkg::MAX_POINTS];
  logic [2:0]            labels [kml_pkg::MAX_POINTS];
  kml_pkg::point_t       pt_rdata;
  logic [DIST_W-1:0]     nd_rdata;
  logic [2:0]            lab_rdata;
  logic [PT_AW-1:0]      raddr;
  logic                  pst_we, nd_we, lab_we;
  logic [DIST_W-1:0]     nd_wd;
  logic [2:0]            lab_wd;
  kml_pkg::point_t       load_vec;

  // result queue and pending stage
  kml_pkg::result_t      rq [kml_pkg::FIFO_DEPTH];
  logic [1:0]            rq_wp, rq_rp;
  logic [2:0]            rq_count;
  logic                  pend_v, pend_use_label;
  logic [1:0]            pend_status;
  logic                  push, pop;
  kml_pkg::result_t      push_data;

  logic                  in_fire;
  logic                  dist_done;
  logic [DIST_W-1:0]     sqdist;
  kml_pkg::dist_req_t    dreq;
  kml_pkg::point_t       ctr_sel;
  logic                  div_start, div_done;
  kml_pkg::coord_t       div_q;
  kml_pkg::sum_row_t     sum_rd;
  logic [CL_W-1:0]       sum_sel;
  logic [DIST_W-1:0]     newnd;
  logic [TOT_W-1:0]      cum_n;
  logic [CNT_W-1:0]      k_tmp;
  logic [kml_pkg::DIM_CW-1:0] dims_eff;
  logic                  idx_last, c_last, cc_last, uc_last, take;

  assign in_ready = (state == S_IDLE) && ((rq_count + {2'b0, pend_v}) <= 3'd2);
  assign in_fire  = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  assign idx_last = (CNT_W'(idx) + 1'b1) == pt_total;
  assign c_last   = (K_W'(c) + 1'b1) == k_r;
  assign cc_last  = (K_W'(cc) + 1'b1) == k_r;
  assign uc_last  = (K_W'(uc) + 1'b1) == k_r;
  assign take     = (cc == '0) || (sqdist < bd);
  assign newnd    = ((c == CL_W'(1)) || (sqdist < cur_nd)) ? sqdist : cur_nd;
  assign cum_n    = cum + TOT_W'(nd_rdata);

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      case (d)
        0: load_vec[d] = coord_0;
        1: load_vec[d] = coord_1;
        2: load_vec[d] = coord_2;
        3: load_vec[d] = coord_3;
        default: load_vec[d] = '0;
      endcase
    end
  end

  // effective cluster count and dimensions for a run
  always_comb begin
    k_tmp = CNT_W'(num_clusters);
    if (k_tmp > CNT_W'(kml_pkg::MAX_CLUSTERS)) k_tmp = CNT_W'(kml_pkg::MAX_CLUSTERS);
    if (k_tmp > pt_total) k_tmp = pt_total;
    if (dims_in_use == 3'd0) dims_eff = kml_pkg::DIM_CW'(1);
    else if (32'(dims_in_use) > DIMS) dims_eff = kml_pkg::DIM_CW'(DIMS);
    else dims_eff = kml_pkg::DIM_CW'(dims_in_use);
  end

  // memory ports
  assign raddr  = (state == S_IDLE) ? point_index[PT_AW-1:0] : idx;
  assign pst_we = in_fire && (kind == kml_pkg::KIND_LOAD)
                  && (pt_total != CNT_W'(kml_pkg::MAX_POINTS));
  assign nd_we  = (state == S_NDP_DIST) && dist_done;
  assign nd_wd  = newnd;
  assign lab_we = (state == S_CLR) || ((state == S_AS_WB) && (best != cur_lab));
  assign lab_wd = (state == S_CLR) ? 3'd0 : 3'(best);

  always_ff @(posedge clk) begin
    if (pst_we) pstore[pt_total[PT_AW-1:0]] <= load_vec;
    pt_rdata <= pstore[raddr];
  end

  always_ff @(posedge clk) begin
    if (nd_we) ndist[idx] <= nd_wd;
    nd_rdata <= ndist[raddr];
  end

  always_ff @(posedge clk) begin
    if (lab_we) labels[idx] <= lab_wd;
    lab_rdata <= labels[raddr];
  end

  // center and sum selection, one read address each
  assign ctr_sel   = (state == S_NDP_ST) ? centers[c - 1'b1] : centers[cc];
  assign sum_sel   = (state == S_AS_WB) ? best : uc;
  assign sum_rd    = sums[sum_sel];
  assign dreq.start = (state == S_NDP_ST) || (state == S_AS_ST);
  assign dreq.dims  = dims_r;
  assign div_start = (state == S_UPD) && (counts[uc] != '0);

  kml_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .req    (dreq),
    .pt     (cur_pt),
    .ctr    (ctr_sel),
    .done   (dist_done),
    .sqdist (sqdist)
  );

  kml_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ($signed(sum_rd[ud])),
    .divisor  (counts[uc]),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pt_total   <= '0;
      frac_total <= '0;
      last_it    <= '0;
      ran        <= 1'b0;
      pend_v     <= 1'b0;
      for (int i = 0; i < kml_pkg::MAX_CLUSTERS; i++) frac_tab[i] <= '0;
    end else begin
      pend_v <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            pend_v         <= (kind != kml_pkg::KIND_RUN);
            pend_use_label <= 1'b0;
            pend_status    <= kml_pkg::STATUS_OK;
            case (kind)
              kml_pkg::KIND_CLEAR: begin
                pt_total   <= '0;
                frac_total <= '0;
                for (int i = 0; i < kml_pkg::MAX_CLUSTERS; i++) frac_tab[i] <= '0;
              end
              kml_pkg::KIND_LOAD: begin
                if (pt_total == CNT_W'(kml_pkg::MAX_POINTS)) pend_status <= kml_pkg::STATUS_FULL;
                else pt_total <= pt_total + 1'b1;
              end
              kml_pkg::KIND_FRAC: begin
                frac_tab[frac_total] <= fraction;
                frac_total           <= frac_total + 1'b1;
              end
              kml_pkg::KIND_RUN: begin
                last_it <= '0;
                ran     <= 1'b1;
                idx     <= '0;
                state   <= S_CLR;
              end
              kml_pkg::KIND_READ: begin
                if (CNT_W'(point_index) >= pt_total) pend_status <= kml_pkg::STATUS_BAD_IDX;
                else pend_use_label <= ran;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          idx <= idx + 1'b1;
          if (idx == PT_AW'(kml_pkg::MAX_POINTS - 1)) begin
            k_r        <= K_W'(k_tmp);
            dims_r     <= dims_eff;
            idx        <= '0;
            run_status <= kml_pkg::STATUS_OK;
            if (pt_total == '0) begin
              run_status <= kml_pkg::STATUS_NO_PTS;
              state      <= S_DONE;
            end else if (k_tmp == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_SEED0_RD;
            end
          end
        end
        S_SEED0_RD: state <= S_SEED0_WR;
        S_SEED0_WR: begin
          centers[0] <= pt_rdata;
          c          <= CL_W'(1);
          idx        <= '0;
          total      <= '0;
          it         <= '0;
          state      <= (k_r == K_W'(1)) ? S_RND : S_NDP_RD;
        end
        // nearest-distance pass against the newest center
        S_NDP_RD: state <= S_NDP_LAT;
        S_NDP_LAT: begin
          cur_pt <= pt_rdata;
          cur_nd <= nd_rdata;
          state  <= S_NDP_ST;
        end
        S_NDP_ST: state <= S_NDP_DIST;
        S_NDP_DIST: begin
          if (dist_done) begin
            total <= total + TOT_W'(newnd);
            if (idx_last) state <= S_THR1;
            else begin
              idx   <= idx + 1'b1;
              state <= S_NDP_RD;
            end
          end
        end
        // threshold = ceil(fraction * total / 2^16), split product
        S_THR1: begin
          if (total == '0) begin
            idx   <= PT_AW'(c);
            state <= S_SETC_RD;
          end else begin
            p_lo  <= frac_tab[c - 1'b1] * total[15:0];
            p_hi  <= frac_tab[c - 1'b1] * total[TOT_W-1:16];
            state <= S_THR2;
          end
        end
        S_THR2: begin
          thr   <= p_hi + TOT_W'(p_lo[31:16]) + TOT_W'(p_lo[15:0] != 16'd0);
          cum   <= '0;
          idx   <= '0;
          state <= S_CUM_RD;
        end
        S_CUM_RD: state <= S_CUM_CHK;
        S_CUM_CHK: begin
          if (cum_n >= thr) state <= S_SETC_RD;
          else begin
            cum   <= cum_n;
            idx   <= idx + 1'b1;
            state <= S_CUM_RD;
          end
        end
        S_SETC_RD: state <= S_SETC_WR;
        S_SETC_WR: begin
          centers[c] <= pt_rdata;
          idx        <= '0;
          total      <= '0;
          if (c_last) state <= S_RND;
          else begin
            c     <= c + 1'b1;
            state <= S_NDP_RD;
          end
        end
        // Lloyd round: assign and accumulate in one pass
        S_RND: begin
          if (it == max_iterations) state <= S_DONE;
          else begin
            changed <= 1'b0;
            idx     <= '0;
            cc      <= '0;
            for (int i = 0; i < kml_pkg::MAX_CLUSTERS; i++) begin
              sums[i]   <= '0;
              counts[i] <= '0;
            end
            state <= S_AS_RD;
          end
        end
        S_AS_RD: begin
          cc    <= '0;
          state <= S_AS_LAT;
        end
        S_AS_LAT: begin
          cur_pt  <= pt_rdata;
          cur_lab <= lab_rdata;
          state   <= S_AS_ST;
        end
        S_AS_ST: state <= S_AS_DIST;
        S_AS_DIST: begin
          if (dist_done) begin
            if (take) begin
              bd   <= sqdist;
              best <= cc;
            end
            if (cc_last) state <= S_AS_WB;
            else begin
              cc    <= cc + 1'b1;
              state <= S_AS_ST;
            end
          end
        end
        S_AS_WB: begin
          if (best != cur_lab) changed <= 1'b1;
          for (int d = 0; d < DIMS; d++)
            sums[best][d] <= sum_rd[d] + kml_pkg::SUM_W'($signed(cur_pt[d]));
          counts[best] <= counts[best] + 1'b1;
          if (idx_last) state <= S_AS_END;
          else begin
            idx   <= idx + 1'b1;
            state <= S_AS_RD;
          end
        end
        S_AS_END: begin
          if (!changed) state <= S_DONE;
          else begin
            last_it <= it + 1'b1;
            it      <= it + 1'b1;
            uc      <= '0;
            ud      <= '0;
            state   <= S_UPD;
          end
        end
        // mean update; empty clusters keep their center
        S_UPD: begin
          if (counts[uc] != '0) state <= S_UPD_WAIT;
          else if (uc_last) state <= S_RND;
          else uc <= uc + 1'b1;
        end
        S_UPD_WAIT: begin
          if (div_done) begin
            centers[uc][ud] <= div_q;
            state           <= S_UPD;
            if (ud == kml_pkg::DIM_IW'(DIMS - 1)) begin
              ud <= '0;
              if (uc_last) state <= S_RND;
              else uc <= uc + 1'b1;
            end else begin
              ud <= ud + 1'b1;
            end
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // result queue
  assign push = pend_v || (state == S_DONE);
  always_comb begin
    push_data.label         = (pend_v && pend_use_label) ? lab_rdata : 3'd0;
    push_data.iterations    = last_it;
    push_data.points_loaded = pt_total;
    push_data.status        = pend_v ? pend_status : run_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wp    <= '0;
      rq_rp    <= '0;
      rq_count <= '0;
    end else begin
      if (push) begin
        rq[rq_wp] <= push_data;
        rq_wp     <= rq_wp + 1'b1;
      end
      if (pop) rq_rp <= rq_rp + 1'b1;
      rq_count <= rq_count + {2'b0, push} - {2'b0, pop};
    end
  end

  assign out_valid     = rq_count != '0;
  assign label         = rq[rq_rp].label;
  assign iterations    = rq[rq_rp].iterations;
  assign points_loaded = rq[rq_rp].points_loaded;
  assign status        = rq[rq_rp].status;

  // checks
  `KML_ASSERT(a_rq_room, clk, rst, push |-> (rq_count != 3'(kml_pkg::FIFO_DEPTH)), "result queue overflow")
  `KML_ASSERT(a_busy_blocks, clk, rst, (state != S_IDLE) |-> !in_ready, "input taken during run")
  `KML_ASSERT(a_run_starts, clk, rst, (in_fire && (kind == kml_pkg::KIND_RUN)) |=> (state == S_CLR), "run did not start clear pass")
  `KML_ASSERT(a_pts_bound, clk, rst, pt_total <= CNT_W'(kml_pkg::MAX_POINTS), "point count beyond store")
  `KML_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE), "not idle after reset")

endmodule
